// File: hw/rtl/pixel_format_packer_unit_assert.svh
// Assertion macros shared by the checker of the pixel format packer.
// No dependencies; taken in by `include.
`ifndef PIXEL_FORMAT_PACKER_UNIT_ASSERT_SVH
`define PIXEL_FORMAT_PACKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while rstn is low
`define PFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while rstn is low
`define PFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pfp_pkg.sv
// Shared types, constants and helper functions of the pixel format packer.
// No dependencies.
`default_nettype none

package pfp_pkg;

    localparam int STAGES    = 6;   // five datapath stages plus the output register
    localparam int CHAN_W    = 16;
    localparam int VAL_W     = 8;
    localparam int WORD_W    = 32;
    localparam int SHIFT_W   = 5;
    localparam int PROD_W    = 40;  // 8 x 32 product plus rounding
    localparam int QUOT_W    = 33;
    localparam int REM_W     = 11;
    localparam int FMT_W     = 2;
    localparam int IDX_W     = 3;

    localparam logic [VAL_W-1:0]  CHAN_MAX = 8'd255;
    localparam logic [PROD_W-1:0] ROUND    = 40'd127;
    localparam logic [PROD_W-1:0] DIVISOR  = 40'd255;
    localparam int                TOP_BYTE = 24;

    localparam logic [FMT_W-1:0] FMT_RGBX    = 2'd0;
    localparam logic [FMT_W-1:0] FMT_BGRX    = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BITMASK = 2'd2;
    localparam logic [FMT_W-1:0] FMT_NONE    = 2'd3;

    localparam logic [IDX_W-1:0] REG_FORMAT = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED    = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BLUE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPARE  = 3'd4;

    typedef struct packed {
        logic [STAGES-1:0] load;   // stage k takes a new word this cycle
    } pfp_ctrl_t;

    function automatic logic [VAL_W-1:0] pfp_clamp(input logic [CHAN_W-1:0] v);
        logic [VAL_W-1:0] r;
        r = (v > CHAN_W'(CHAN_MAX)) ? CHAN_MAX : v[VAL_W-1:0];
        return r;
    endfunction

    // trailing zero count; zero mask gives 0 and is flagged separately
    function automatic logic [SHIFT_W-1:0] pfp_tzc(input logic [WORD_W-1:0] m);
        logic [SHIFT_W-1:0] n;
        n = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                n = SHIFT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pfp_ctrl.sv
// Valid tracking and per-stage ready chain of the packer pipeline.
// Depends on pfp_pkg.
`default_nettype none

module pfp_ctrl import pfp_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output pfp_ctrl_t ctl
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] can;

    // a stage may load when it is empty or its word moves on this cycle
    always_comb begin
        can[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            can[k] = !valid_reg[k] || can[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        for (int k = 0; k < STAGES; k++) begin
            if (can[k]) begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = can[0];
    assign out_valid = valid_reg[STAGES-1];
    assign ctl.load  = can;

endmodule

`default_nettype wire

// File: hw/rtl/pfp_chan.sv
// One colour channel of bitmask mode: clamp, mask shift, scale by max/255
// with rounding, and placement. Depends on pfp_pkg.
`default_nettype none

module pfp_chan import pfp_pkg::*; (
    input  wire logic              aclk,
    input  wire pfp_ctrl_t         ctl,
    input  wire logic [CHAN_W-1:0] chan_in,
    input  wire logic [WORD_W-1:0] mask_in,
    output logic      [WORD_W-1:0] placed
);

    logic [VAL_W-1:0]   v0_reg, v1_reg;
    logic [WORD_W-1:0]  mask0_reg, max1_reg;
    logic [SHIFT_W-1:0] sh0_reg, sh1_reg, sh2_reg, sh3_reg, sh4_reg;
    logic               nz0_reg, nz1_reg, nz2_reg, nz3_reg, nz4_reg;
    logic [PROD_W-1:0]  x2_reg, x3_reg;
    logic [QUOT_W-1:0]  qe3_reg, q4_reg;

    logic [PROD_W-1:0]  x2_next;
    logic [QUOT_W-1:0]  qe3_next, q4_next;
    logic [PROD_W-1:0]  rem_full;
    logic [REM_W-1:0]   rem;
    logic [REM_W-1:0]   corr_sum;
    logic [63:0]        shifted;

    assign x2_next = (PROD_W'(v1_reg) * PROD_W'(max1_reg)) + ROUND;

    // x/255 as x/256 + x/256^2 + ...; each floor loses under one, so the
    // estimate is at most five short and the remainder stays below 1530
    assign qe3_next = QUOT_W'(x2_reg >> 8) + QUOT_W'(x2_reg >> 16)
                    + QUOT_W'(x2_reg >> 24) + QUOT_W'(x2_reg >> 32);

    assign rem_full = x3_reg - (PROD_W'(qe3_reg) * DIVISOR);
    assign rem      = rem_full[REM_W-1:0];
    // floor(r/255) for small r
    assign corr_sum = rem + (rem >> 8) + REM_W'(1);
    assign q4_next  = qe3_reg + QUOT_W'(corr_sum[REM_W-1:8]);

    assign shifted = 64'(q4_reg) << sh4_reg;
    assign placed  = nz4_reg ? shifted[WORD_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            v0_reg    <= pfp_clamp(chan_in);
            mask0_reg <= mask_in;
            sh0_reg   <= pfp_tzc(mask_in);
            nz0_reg   <= |mask_in;
        end
        if (ctl.load[1]) begin
            v1_reg   <= v0_reg;
            max1_reg <= mask0_reg >> sh0_reg;
            sh1_reg  <= sh0_reg;
            nz1_reg  <= nz0_reg;
        end
        if (ctl.load[2]) begin
            x2_reg  <= x2_next;
            sh2_reg <= sh1_reg;
            nz2_reg <= nz1_reg;
        end
        if (ctl.load[3]) begin
            x3_reg  <= x2_reg;
            qe3_reg <= qe3_next;
            sh3_reg <= sh2_reg;
            nz3_reg <= nz2_reg;
        end
        if (ctl.load[4]) begin
            q4_reg  <= q4_next;
            sh4_reg <= sh3_reg;
            nz4_reg <= nz3_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pixel_format_packer_unit.sv
// Pixel format packer: RGB triple in, 32-bit framebuffer word out.
// Use: write the format and masks on the cfg port while idle, then stream
// pixels on s_axis; one word leaves on m_axis per pixel, in order.
// Format 0 packs R,G,B,FF from the low byte up, format 1 B,G,R,FF,
// format 2 scales each channel to its mask and ORs in the spare mask,
// format 3 gives zero. Channels above 255 saturate.
// Throughput: one word per cycle while m_tready is high, set by the
// six-stage pipeline (tzc, mask shift, multiply, divide estimate,
// correction, merge), whose last stage is the output register.
// Each stage loads when empty or draining, so a stalled receiver only
// backs up the pipe as far as it is full; s_tready falls only when all
// six stages hold a word. Nothing is lost or repeated under stall.
// Reset (synchronous, aresetn low) empties the pipe and clears the
// configuration to format 0 with all masks zero.
// Depends on pfp_pkg, pfp_ctrl, pfp_chan.
`default_nettype none

module pixel_format_packer_unit import pfp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // red_in, green_in, blue_in
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [WORD_W-1:0] m_tdata,   // pixel_word
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [WORD_W-1:0] cfg_wdata
);

    localparam int PIPE = STAGES - 1;

    logic [FMT_W-1:0]  fmt_reg;
    logic [WORD_W-1:0] red_mask_reg, green_mask_reg, blue_mask_reg, spare_mask_reg;

    pfp_ctrl_t ctl;

    logic [FMT_W-1:0]  fmt_pipe_reg    [PIPE];
    logic [WORD_W-1:0] direct_pipe_reg [PIPE];
    logic [WORD_W-1:0] spare_pipe_reg  [PIPE];
    logic [WORD_W-1:0] out_reg;
    logic [WORD_W-1:0] out_next;
    logic [WORD_W-1:0] direct_next;
    logic [VAL_W-1:0]  r8, g8, b8;
    logic [WORD_W-1:0] red_placed, green_placed, blue_placed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg        <= FMT_RGBX;
            red_mask_reg   <= '0;
            green_mask_reg <= '0;
            blue_mask_reg  <= '0;
            spare_mask_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FORMAT: fmt_reg        <= cfg_wdata[FMT_W-1:0];
                REG_RED:    red_mask_reg   <= cfg_wdata;
                REG_GREEN:  green_mask_reg <= cfg_wdata;
                REG_BLUE:   blue_mask_reg  <= cfg_wdata;
                REG_SPARE:  spare_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pfp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    pfp_chan u_red (
        .aclk (aclk), .ctl (ctl), .chan_in (s_tdata[15:0]),
        .mask_in (red_mask_reg), .placed (red_placed)
    );
    pfp_chan u_green (
        .aclk (aclk), .ctl (ctl), .chan_in (s_tdata[31:16]),
        .mask_in (green_mask_reg), .placed (green_placed)
    );
    pfp_chan u_blue (
        .aclk (aclk), .ctl (ctl), .chan_in (s_tdata[47:32]),
        .mask_in (blue_mask_reg), .placed (blue_placed)
    );

    assign r8 = pfp_clamp(s_tdata[15:0]);
    assign g8 = pfp_clamp(s_tdata[31:16]);
    assign b8 = pfp_clamp(s_tdata[47:32]);

    always_comb begin
        case (fmt_reg)
            FMT_RGBX: direct_next = {CHAN_MAX, b8, g8, r8};
            FMT_BGRX: direct_next = {CHAN_MAX, r8, g8, b8};
            default:  direct_next = '0;
        endcase
    end

    // byte-formats bypass the scaling path and ride along with it
    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            fmt_pipe_reg[0]    <= fmt_reg;
            direct_pipe_reg[0] <= direct_next;
            spare_pipe_reg[0]  <= spare_mask_reg;
        end
        for (int k = 1; k < PIPE; k++) begin
            if (ctl.load[k]) begin
                fmt_pipe_reg[k]    <= fmt_pipe_reg[k-1];
                direct_pipe_reg[k] <= direct_pipe_reg[k-1];
                spare_pipe_reg[k]  <= spare_pipe_reg[k-1];
            end
        end
    end

    assign out_next = (fmt_pipe_reg[PIPE-1] == FMT_BITMASK)
                    ? (red_placed | green_placed | blue_placed | spare_pipe_reg[PIPE-1])
                    : direct_pipe_reg[PIPE-1];

    always_ff @(posedge aclk) begin
        if (ctl.load[STAGES-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pfp_checker.sv
// Port-level checker for the pixel format packer and its bind.
// Depends on pixel_format_packer_unit_assert.svh.
`default_nettype none

`include "pixel_format_packer_unit_assert.svh"

module pfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a stalled output word holds
    `PFP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed under stall")
    // a draining receiver never back-pressures the input
    `PFP_ASSERT_NOW(a_drain_ready, aclk, aresetn, m_tready, s_tready, "s_tready low while m_tready high")
    // input back-pressure only comes from a full, stalled output
    `PFP_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "s_tready low without output stall")
    // reset empties the pipe
    `PFP_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid, "m_tvalid high after reset")

endmodule

bind pixel_format_packer_unit pfp_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/tb_pixel_format_packer_unit.sv
// Self-checking testbench for pixel_format_packer_unit: directed table, then
// randomised phases across formats and masks, with idling on both streams.
// Depends on pfp_pkg and the pixel_format_packer_unit RTL.

module tb_pixel_format_packer_unit;
    import pfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 850;
    localparam int PHASES      = 12;
    localparam int END_WAIT    = 5000;
    localparam int DIR_ROWS    = 25;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata   = '0;   // red_in, green_in, blue_in
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [WORD_W-1:0] m_tdata;          // pixel_word
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0] cfg_wdata = '0;

    // local copy of the configuration
    logic [FMT_W-1:0]  cur_format     = FMT_RGBX;
    logic [WORD_W-1:0] cur_red_mask   = '0;
    logic [WORD_W-1:0] cur_green_mask = '0;
    logic [WORD_W-1:0] cur_blue_mask  = '0;
    logic [WORD_W-1:0] cur_spare_mask = '0;

    logic [WORD_W-1:0] pending_words [$];
    int                err_count   = 0;
    int                cycle_count = 0;
    bit                no_stall    = 1'b0;

    typedef struct {
        bit                load;
        logic [FMT_W-1:0]  fmt;
        logic [WORD_W-1:0] rm, gm, bm, sm;
        logic [15:0]       r, g, b;
        bit                typed;
        logic [WORD_W-1:0] word;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // reset configuration: red low byte, no masks
        '{1'b0, FMT_RGBX, 32'h0, 32'h0, 32'h0, 32'h0,
          16'h0012, 16'h0034, 16'h0056, 1'b1, 32'hFF56_3412},
        '{1'b0, FMT_RGBX, 32'h0, 32'h0, 32'h0, 32'h0,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF},
        '{1'b0, FMT_RGBX, 32'h0, 32'h0, 32'h0, 32'h0,
          16'h0100, 16'h00FF, 16'h0000, 1'b1, 32'hFF00_FFFF},
        '{1'b0, FMT_RGBX, 32'h0, 32'h0, 32'h0, 32'h0,
          16'h0000, 16'h0000, 16'h0000, 1'b1, 32'hFF00_0000},
        '{1'b1, FMT_BGRX, 32'h0, 32'h0, 32'h0, 32'h0,
          16'h0012, 16'h0034, 16'h0056, 1'b1, 32'hFF12_3456},
        '{1'b0, FMT_BGRX, 32'h0, 32'h0, 32'h0, 32'h0,
          16'h8000, 16'h0000, 16'h0001, 1'b1, 32'hFFFF_0001},
        // byte formats ignore the masks
        '{1'b1, FMT_RGBX, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'hFFFF_0000,
          16'h00AB, 16'h0120, 16'h00CD, 1'b0, 32'h0},
        '{1'b1, FMT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0},
        '{1'b0, FMT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          16'h0012, 16'h0034, 16'h0056, 1'b1, 32'h0},
        '{1'b1, FMT_BITMASK, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000,
          16'h0012, 16'h0034, 16'h0056, 1'b1, 32'hFF12_3456},
        '{1'b0, FMT_BITMASK, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF},
        '{1'b0, FMT_BITMASK, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000,
          16'h0000, 16'h0000, 16'h0000, 1'b1, 32'hFF00_0000},
        '{1'b1, FMT_BITMASK, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0,
          16'h00FF, 16'h00FF, 16'h00FF, 1'b1, 32'h0000_FFFF},
        '{1'b0, FMT_BITMASK, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0,
          16'h0080, 16'h0040, 16'h00C8, 1'b0, 32'h0},
        // no colour masks, with and without spare bits; then one full-width mask
        '{1'b1, FMT_BITMASK, 32'h0, 32'h0, 32'h0, 32'h0,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0},
        '{1'b1, FMT_BITMASK, 32'h0, 32'h0, 32'h0, 32'h0F0F_0F0F,
          16'h0012, 16'h0034, 16'h0056, 1'b1, 32'h0F0F_0F0F},
        '{1'b1, FMT_BITMASK, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
          16'h00FF, 16'h0000, 16'h0000, 1'b1, 32'hFFFF_FFFF},
        '{1'b0, FMT_BITMASK, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
          16'h0001, 16'h0000, 16'h0000, 1'b0, 32'h0},
        // one-bit field at the top: rounds at 127/128
        '{1'b1, FMT_BITMASK, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
          16'h00C8, 16'h0000, 16'h0000, 1'b1, 32'h8000_0000},
        '{1'b0, FMT_BITMASK, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
          16'h007F, 16'h0000, 16'h0000, 1'b1, 32'h0},
        '{1'b0, FMT_BITMASK, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
          16'h0080, 16'h0000, 16'h0000, 1'b1, 32'h8000_0000},
        '{1'b1, FMT_BITMASK, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0,
          16'h00FF, 16'h0000, 16'h0000, 1'b1, 32'hFFFF_FFFE},
        // masks with holes, overlapping each other
        '{1'b1, FMT_BITMASK, 32'h0000_0101, 32'h00F0_F000, 32'h3FF0_0000, 32'hC000_0003,
          16'h00A5, 16'h005A, 16'h00C3, 1'b0, 32'h0},
        '{1'b0, FMT_BITMASK, 32'h0000_0101, 32'h00F0_F000, 32'h3FF0_0000, 32'hC000_0003,
          16'h0100, 16'hFFFF, 16'h0200, 1'b0, 32'h0},
        '{1'b1, FMT_BITMASK, 32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF, 32'hC000_0000,
          16'h0007, 16'h00F8, 16'h0081, 1'b0, 32'h0}
    };

    pixel_format_packer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] sat_channel(logic [15:0] v);
        return (v > 16'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [WORD_W-1:0] scale_to_mask(logic [7:0] v, logic [WORD_W-1:0] m);
        int          s;
        logic [63:0] maxv;
        logic [63:0] scaled;
        if (m == '0) return '0;
        s = 0;
        while (!m[s]) s++;
        maxv   = 64'(m >> s);
        scaled = (64'(v) * maxv + 64'd127) / 64'd255;
        return WORD_W'(scaled << s);
    endfunction

    function automatic logic [WORD_W-1:0] pack_pixel(logic [15:0] r_in, logic [15:0] g_in,
                                                     logic [15:0] b_in);
        logic [7:0]        r, g, b;
        logic [WORD_W-1:0] w;
        r = sat_channel(r_in);
        g = sat_channel(g_in);
        b = sat_channel(b_in);
        case (cur_format)
            FMT_RGBX:    w = {CHAN_MAX, b, g, r};
            FMT_BGRX:    w = {CHAN_MAX, r, g, b};
            FMT_BITMASK: w = scale_to_mask(r, cur_red_mask) | scale_to_mask(g, cur_green_mask)
                             | scale_to_mask(b, cur_blue_mask) | cur_spare_mask;
            default:     w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] rand_mask();
        logic [WORD_W-1:0] m;
        int                w, pos;
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = '1;
            2: m = $urandom;
            3: m = 32'h1 << $urandom_range(0, 31);
            default: begin
                w   = $urandom_range(1, 32);
                pos = $urandom_range(0, 32 - w);
                m   = 32'((64'h1 << w) - 64'h1) << pos;
            end
        endcase
        return m;
    endfunction

    function automatic logic [15:0] rand_channel();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h0000;
            1:       v = 16'h00FF;
            2:       v = 16'($urandom_range(256, 65535));
            3:       v = 16'($urandom);
            default: v = 16'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Leaves cfg_we high; the caller drops it after the last write.
    task automatic reg_write(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_format(logic [FMT_W-1:0] fmt, logic [WORD_W-1:0] rm,
                               logic [WORD_W-1:0] gm, logic [WORD_W-1:0] bm,
                               logic [WORD_W-1:0] sm);
        logic [WORD_W-1:0] junk;
        junk = $urandom;
        // upper bits of the format word are don't-care
        reg_write(REG_FORMAT, {junk[WORD_W-1:FMT_W], fmt});
        reg_write(REG_RED, rm);
        reg_write(REG_GREEN, gm);
        reg_write(REG_BLUE, bm);
        reg_write(REG_SPARE, sm);
        // an unused index must leave everything alone
        reg_write(IDX_W'(REG_SPARE + 1 + $urandom_range(0, 2)), $urandom);
        cfg_we <= 1'b0;
        cur_format     = fmt;
        cur_red_mask   = rm;
        cur_green_mask = gm;
        cur_blue_mask  = bm;
        cur_spare_mask = sm;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic push_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              bit typed, logic [WORD_W-1:0] word);
        while (!no_stall && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        pending_words.push_back(typed ? word : pack_pixel(r, g, b));
    endtask

    task automatic random_setup(int phase);
        logic [WORD_W-1:0] rm, gm, bm, sm;
        logic [FMT_W-1:0]  fmt;
        int                pick;
        pick = $urandom_range(0, 9);
        fmt  = (pick < 2) ? FMT_RGBX : (pick == 2) ? FMT_BGRX :
               (pick == 3) ? FMT_NONE : FMT_BITMASK;
        case ($urandom_range(0, 4))
            0: begin
                rm = 32'h00FF_0000; gm = 32'h0000_FF00; bm = 32'h0000_00FF;
                sm = $urandom_range(0, 1) ? 32'hFF00_0000 : 32'h0;
                if ($urandom_range(0, 1)) begin
                    rm = 32'h0000_00FF;
                    bm = 32'h00FF_0000;
                end
            end
            1: begin
                rm = 32'h0000_F800; gm = 32'h0000_07E0; bm = 32'h0000_001F; sm = 32'h0;
            end
            2: begin
                rm = 32'h3FF0_0000; gm = 32'h000F_FC00; bm = 32'h0000_03FF; sm = 32'hC000_0000;
            end
            default: begin
                rm = rand_mask(); gm = rand_mask(); bm = rand_mask(); sm = rand_mask();
            end
        endcase
        // first phase: widest masks everywhere
        if (phase == 0) begin
            fmt = FMT_BITMASK;
            rm = '1; gm = '1; bm = '1; sm = '0;
        end
        load_format(fmt, rm, gm, bm, sm);
    endtask

    // receiver
    always @(posedge aclk) begin
        m_tready <= no_stall || ($urandom_range(0, 99) >= 8);
    end

    // result checker
    always @(posedge aclk) begin
        logic [WORD_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("pixel_word: word received with nothing expected, got %08h", m_tdata);
                err_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_tdata !== want) begin
                    $error("pixel_word mismatch: expected %08h, got %08h", want, m_tdata);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** pixel_format_packer_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int per_phase, n, waited;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].load) begin
                wait_drained();
                load_format(dir_rows[i].fmt, dir_rows[i].rm, dir_rows[i].gm,
                            dir_rows[i].bm, dir_rows[i].sm);
            end
            push_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                       dir_rows[i].typed, dir_rows[i].word);
        end

        per_phase = RAND_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            random_setup(p);
            // a long run with both sides streaming flat out
            no_stall = (p == 5 || p == 6);
            n = (p == PHASES - 1) ? RAND_ITEMS - per_phase * (PHASES - 1) : per_phase;
            for (int k = 0; k < n; k++) begin
                push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, '0);
            end
        end
        no_stall = 1'b0;

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_words.size() != 0 && waited < END_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (2 * STAGES) @(posedge aclk);
        if (pending_words.size() != 0) begin
            $error("pixel_word: %0d expected words never arrived", pending_words.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("** pixel_format_packer_unit: PASSED **");
        end else begin
            $display("** pixel_format_packer_unit: FAILED **");
        end
        $finish;
    end

endmodule
